@@ design/csvt_pkg.sv @@
// shared types and character constants of the csv tokenizer
`timescale 1ns / 1ps

package csvt_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] COLOR_RESET = 8'd28;

  typedef enum logic [1:0] {
    TK_DATA     = 2'd0,
    TK_CELL_END = 2'd1,
    TK_ROW_END  = 2'd2
  } token_kind_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] out_byte;
    logic       last;
  } token_t;

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic escape_pending;
    logic cell_begun;
    logic row_begun;
    logic cell_cut;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_res_t;

endpackage

@@ design/csvt_if.sv @@
// valid/ready channel interfaces of the csv tokenizer
`timescale 1ns / 1ps

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output token_kind, output out_byte, output last,
                  input ready);
  modport sink (input valid, input token_kind, input out_byte, input last,
                output ready);
endinterface

interface csvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_escape_byte;
  modport source (output valid, output color_escape_byte, input ready);
  modport sink (input valid, input color_escape_byte, output ready);
endinterface

@@ design/csvt_step.sv @@
// per-byte parse step: next state and up to two tokens
`timescale 1ns / 1ps

module csvt_step (
  input  csvt_pkg::parse_state_t st,
  input  logic [7:0]             in_byte,
  input  logic                   end_of_input,
  input  logic [7:0]             color,
  output csvt_pkg::parse_state_t st_next,
  output csvt_pkg::step_res_t    res
);

  always_comb begin
    csvt_pkg::parse_state_t s;
    logic       done;
    logic       do_raw;
    logic [7:0] raw_b;
    logic       do_end;
    logic [1:0] end_kind;
    logic       do_data;
    logic [7:0] d;
    logic [1:0] n;
    csvt_pkg::token_t t0;
    csvt_pkg::token_t t1;

    s        = st;
    done     = 1'b0;
    do_raw   = 1'b0;
    raw_b    = in_byte;
    do_end   = 1'b0;
    end_kind = csvt_pkg::TK_CELL_END;
    do_data  = 1'b0;
    d        = in_byte;
    n        = 2'd0;
    t0       = '0;
    t1       = '0;

    // quote seen inside quotes: doubled quote or closing quote
    if (s.quote_pending) begin
      s.quote_pending = 1'b0;
      if (in_byte == csvt_pkg::CH_QUOTE) begin
        do_raw = 1'b1;
        done   = 1'b1;
      end else begin
        s.in_quotes = 1'b0;
      end
    end

    if (!done) begin
      priority if (in_byte == csvt_pkg::CH_QUOTE) begin
        if (s.in_quotes) begin
          if (end_of_input) s.in_quotes = 1'b0;
          else s.quote_pending = 1'b1;
        end else if (!s.cell_begun) begin
          s.in_quotes = 1'b1;
        end
      end else if (in_byte == csvt_pkg::CH_COMMA) begin
        if (!s.in_quotes) begin
          do_end      = 1'b1;
          end_kind    = csvt_pkg::TK_CELL_END;
          s.row_begun = 1'b1;
        end else begin
          do_raw = 1'b1;
        end
      end else if (in_byte == csvt_pkg::CH_CR) begin
        do_raw = 1'b0;
      end else if (in_byte == csvt_pkg::CH_LF && !s.in_quotes) begin
        do_end      = 1'b1;
        end_kind    = csvt_pkg::TK_ROW_END;
        s.row_begun = 1'b0;
      end else begin
        do_raw = 1'b1;
      end
    end

    // raw cell byte with escape resolution
    if (do_raw) begin
      s.cell_begun = 1'b1;
      if (!s.cell_cut) begin
        if (s.escape_pending) begin
          s.escape_pending = 1'b0;
          if (raw_b != csvt_pkg::CH_LF) begin
            do_data = 1'b1;
            priority if (raw_b == csvt_pkg::CH_N) d = csvt_pkg::CH_LF;
            else if (raw_b == csvt_pkg::CH_C) d = color;
            else if (raw_b == csvt_pkg::CH_R) d = csvt_pkg::CH_CR;
            else if (raw_b == csvt_pkg::CH_T) d = csvt_pkg::CH_TAB;
            else d = raw_b;
          end
        end else if (raw_b == csvt_pkg::CH_BSLASH) begin
          s.escape_pending = 1'b1;
        end else begin
          do_data = 1'b1;
          d       = raw_b;
        end
        if (do_data) begin
          if (d == 8'd0) begin
            s.cell_cut = 1'b1;
          end else begin
            t0 = '{token_kind: csvt_pkg::TK_DATA, out_byte: d, last: 1'b0};
            n  = 2'd1;
          end
        end
      end
    end

    // comma or newline closes the cell
    if (do_end) begin
      t0               = '{token_kind: end_kind, out_byte: 8'd0, last: 1'b0};
      n                = 2'd1;
      s.cell_begun     = 1'b0;
      s.escape_pending = 1'b0;
      s.cell_cut       = 1'b0;
    end

    // flush on the final byte
    if (end_of_input) begin
      if (s.cell_begun || s.row_begun) begin
        if (n == 2'd0) begin
          t0 = '{token_kind: csvt_pkg::TK_ROW_END, out_byte: 8'd0, last: 1'b0};
        end else begin
          t1 = '{token_kind: csvt_pkg::TK_ROW_END, out_byte: 8'd0, last: 1'b0};
        end
        n = n + 2'd1;
      end
      s = '0;
    end

    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;

    st_next   = s;
    res.count = n;
    res.tok0  = t0;
    res.tok1  = t1;
  end

endmodule

@@ design/csvt_out_queue.sv @@
// small result queue: two writes, one read per cycle
`timescale 1ns / 1ps

module csvt_out_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  csvt_pkg::step_res_t        push,
  input  logic                       pop,
  output csvt_pkg::token_t           head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  csvt_pkg::token_t slots [DEPTH];
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [PW-1:0] wp1;
  logic [PW-1:0] wp2;
  logic [PW-1:0] rp_next;
  logic [PW-1:0] wp_next;
  logic [CW-1:0] count_next;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1     = inc(wp);
  assign wp2     = inc(wp1);
  assign rp_next = pop ? inc(rp) : rp;
  assign head    = slots[rp];

  always_comb begin
    unique case (push.count)
      2'd1:    wp_next = wp1;
      2'd2:    wp_next = wp2;
      default: wp_next = wp;
    endcase
    count_next = count + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      rp    <= rp_next;
      wp    <= wp_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.count != 2'd0 && PW'(i) == wp) slots[i] <= push.tok0;
      if (push.count == 2'd2 && PW'(i) == wp1) slots[i] <= push.tok1;
    end
  end

endmodule

@@ design/csv_tokenizer_with_escapes_unit.sv @@
// top level of the csv tokenizer with backslash escapes
`timescale 1ns / 1ps

// csv tokenizer: one text byte per input transaction, tokens out
// - in_ch carries in_byte and end_of_input; a transaction is taken when
//   valid and ready are both high at a rising edge of clk
// - out_ch gives one token per transaction: cell data byte, end of cell,
//   or end of cell and row; last marks the final token of an input byte
// - cfg writes the colour byte used for the backslash-c escape; it is
//   always ready and should only be written while the block is idle
// - each byte is decoded by the step logic in the cycle it is taken and
//   its zero, one or two tokens land in the result queue at that edge
// - a queued token is offered on out_ch once the tokens ahead of it go
// - throughput: one byte per cycle while in_ch.ready is high; a byte
//   giving two tokens needs two pops; the sink's drain rate sets the pace
// - in_ch.ready stays high while the queue has room for two tokens, so a
//   stalled receiver holds off input once fewer than two slots are free
// - synchronous reset clears the parse flags and the queue and restores
//   the colour byte to its reset value of 28

module csv_tokenizer_with_escapes_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch,
  csvt_cfg_if.sink   cfg
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  csvt_pkg::parse_state_t st;
  csvt_pkg::parse_state_t st_next;
  csvt_pkg::step_res_t    step_res;
  csvt_pkg::step_res_t    push;
  csvt_pkg::token_t       head;
  logic [7:0]             color;
  logic [CW-1:0]          q_count;
  logic                   in_acc;
  logic                   out_acc;

  // handshakes
  assign in_ch.ready = (q_count <= CW'(QUEUE_DEPTH - 2));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (q_count != '0);
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign cfg.ready   = 1'b1;

  // per-byte decode of quotes, escapes and cell boundaries
  csvt_step u_step (
    .st           (st),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .color        (color),
    .st_next      (st_next),
    .res          (step_res)
  );

  // tokens are only pushed for a taken transaction
  always_comb begin
    push = step_res;
    if (!in_acc) push.count = 2'd0;
  end

  csvt_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .count (q_count)
  );

  assign out_ch.token_kind = head.token_kind;
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.last       = head.last;

  // parse flags and colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      color <= csvt_pkg::COLOR_RESET;
    end else begin
      if (in_acc) st <= st_next;
      if (cfg.valid && cfg.ready) color <= cfg.color_escape_byte;
    end
  end

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // the final byte leaves every parse flag cleared
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.end_of_input) |=> (st == '0))
    else $error("parse state not cleared after final byte");

  // with two tokens only the second carries last
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    (in_acc && step_res.count == 2'd2) |-> (!step_res.tok0.last && step_res.tok1.last))
    else $error("last flag on wrong token");

  // cell and row marks carry a zero byte
  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.token_kind != csvt_pkg::TK_DATA) |-> (out_ch.out_byte == 8'd0))
    else $error("boundary token with nonzero byte");

endmodule

@@ test/csv_tokenizer_with_escapes_unit_tb.sv @@
// self-checking testbench of the csv tokenizer with backslash escapes
`timescale 1ns / 1ps

module csv_tokenizer_with_escapes_unit_tb;

  localparam int PREDICTED  = -1;   // row is checked against the tokenizer model
  localparam int HOLD_LEN   = 300;  // long receiver stall, fills the result queue
  localparam int SETTLE     = 6;    // cycles after the last token before a register write
  localparam int IDLE_LIMIT = 2000; // cycles with no transaction anywhere
  localparam int PHASE_LEN  = 450;
  localparam int PRINT_CAP  = 200;

  // one offered byte; n_typed >= 0 carries a hand-written expectation
  typedef struct {
    logic [7:0] b;
    logic       e;
    int         n_typed;
    logic [1:0] k;
    logic [7:0] d;
  } text_item_t;

  logic clk;
  logic rst;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();
  csvt_cfg_if cfg ();

  csv_tokenizer_with_escapes_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // directed rows: plain bytes, quoting, escapes, zero cut, flush
  localparam int N_DIR = 28;
  text_item_t dir_rows [0:N_DIR-1] = '{
    // plain byte
    '{8'h61,               1'b0, 1,         csvt_pkg::TK_DATA,     8'h61},
    // end of cell
    '{csvt_pkg::CH_COMMA,  1'b0, 1,         csvt_pkg::TK_CELL_END, 8'h00},
    // opens quotes
    '{csvt_pkg::CH_QUOTE,  1'b0, 0,         csvt_pkg::TK_DATA,     8'h00},
    // comma kept in quotes
    '{csvt_pkg::CH_COMMA,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // newline kept in quotes
    '{csvt_pkg::CH_LF,     1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_QUOTE,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // doubled quote
    '{csvt_pkg::CH_QUOTE,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_QUOTE,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // closes quotes, ends row
    '{csvt_pkg::CH_LF,     1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{8'h62,               1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // stray quote
    '{csvt_pkg::CH_QUOTE,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // carriage return
    '{csvt_pkg::CH_CR,     1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_BSLASH, 1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // colour escape, reset value
    '{csvt_pkg::CH_C,      1'b0, 1,         csvt_pkg::TK_DATA,     csvt_pkg::COLOR_RESET},
    '{csvt_pkg::CH_BSLASH, 1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_N,      1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_BSLASH, 1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // escaped newline vanishes
    '{csvt_pkg::CH_LF,     1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_BSLASH, 1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // other byte kept
    '{8'hFF,               1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // zero cuts the cell
    '{8'h00,               1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // suppressed after cut
    '{8'h7A,               1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_BSLASH, 1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // cell end after the cut
    '{csvt_pkg::CH_COMMA,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    '{csvt_pkg::CH_QUOTE,  1'b0, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // quote on final byte, row flush
    '{csvt_pkg::CH_QUOTE,  1'b1, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // data then flush, two tokens
    '{8'h71,               1'b1, PREDICTED, csvt_pkg::TK_DATA,     8'h00},
    // nothing open, no token
    '{csvt_pkg::CH_CR,     1'b1, 0,         csvt_pkg::TK_DATA,     8'h00}
  };

  // tokenizer model state
  logic             q_in_quotes;
  logic             q_quote_wait;
  logic             q_esc_wait;
  logic             q_cell_open;
  logic             q_row_open;
  logic             q_cell_cut;
  logic [7:0]       colour_byte;
  csvt_pkg::token_t byte_tokens[$];

  text_item_t       offered_bytes[$];
  csvt_pkg::token_t expected_tokens[$];

  int  mismatch_count;
  int  items_sent;
  int  idle_cycles;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;

  // ---------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------

  function automatic void add_token(csvt_pkg::token_kind_t k, logic [7:0] d);
    csvt_pkg::token_t t;
    if (byte_tokens.size() >= 2) return;
    t.token_kind = k;
    t.out_byte   = d;
    t.last       = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  // raw byte into the open cell: escape decoding and the zero cut
  function automatic void feed_cell_byte(logic [7:0] b);
    logic [7:0] d;
    q_cell_open = 1'b1;
    if (q_cell_cut) return;
    if (q_esc_wait) begin
      q_esc_wait = 1'b0;
      if (b == csvt_pkg::CH_LF) return;
      case (b)
        csvt_pkg::CH_N: d = csvt_pkg::CH_LF;
        csvt_pkg::CH_C: d = colour_byte;
        csvt_pkg::CH_R: d = csvt_pkg::CH_CR;
        csvt_pkg::CH_T: d = csvt_pkg::CH_TAB;
        default:        d = b;
      endcase
    end else if (b == csvt_pkg::CH_BSLASH) begin
      q_esc_wait = 1'b1;
      return;
    end else begin
      d = b;
    end
    if (d == 8'h00) begin
      q_cell_cut = 1'b1;
      return;
    end
    add_token(csvt_pkg::TK_DATA, d);
  endfunction

  function automatic void close_open_cell(csvt_pkg::token_kind_t k);
    add_token(k, 8'h00);
    q_cell_open = 1'b0;
    q_esc_wait  = 1'b0;
    q_cell_cut  = 1'b0;
  endfunction

  function automatic void clear_parse();
    q_in_quotes  = 1'b0;
    q_quote_wait = 1'b0;
    q_esc_wait   = 1'b0;
    q_cell_open  = 1'b0;
    q_row_open   = 1'b0;
    q_cell_cut   = 1'b0;
  endfunction

  // tokens caused by one text byte, left in byte_tokens
  function automatic void tokenize_byte(logic [7:0] b, logic e);
    bit taken;
    taken = 1'b0;
    byte_tokens.delete();
    if (q_quote_wait) begin
      q_quote_wait = 1'b0;
      if (b == csvt_pkg::CH_QUOTE) begin
        feed_cell_byte(csvt_pkg::CH_QUOTE);
        taken = 1'b1;
      end else begin
        q_in_quotes = 1'b0;
      end
    end
    if (!taken) begin
      if (b == csvt_pkg::CH_QUOTE) begin
        if (q_in_quotes) begin
          if (e) q_in_quotes = 1'b0;
          else q_quote_wait = 1'b1;
        end else if (!q_cell_open) begin
          q_in_quotes = 1'b1;
        end
      end else if (b == csvt_pkg::CH_COMMA) begin
        if (!q_in_quotes) begin
          close_open_cell(csvt_pkg::TK_CELL_END);
          q_row_open = 1'b1;
        end else begin
          feed_cell_byte(b);
        end
      end else if (b == csvt_pkg::CH_CR) begin
        // carriage return dropped
      end else if (b == csvt_pkg::CH_LF && !q_in_quotes) begin
        close_open_cell(csvt_pkg::TK_ROW_END);
        q_row_open = 1'b0;
      end else begin
        feed_cell_byte(b);
      end
    end
    if (e) begin
      if (q_cell_open || q_row_open) close_open_cell(csvt_pkg::TK_ROW_END);
      clear_parse();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and receiver
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req     <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: model update on every byte transaction, token compare, watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    text_item_t       it;
    csvt_pkg::token_t want;
    csvt_pkg::token_t t;
    if (rst) begin
      clear_parse();
      colour_byte = csvt_pkg::COLOR_RESET;
      idle_cycles = 0;
    end else begin
      // byte taken: step the model, queue typed or modelled tokens
      if (in_ch.valid && in_ch.ready) begin
        it = offered_bytes.pop_front();
        tokenize_byte(it.b, it.e);
        if (it.n_typed == PREDICTED) begin
          foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
        end else if (it.n_typed == 1) begin
          t.token_kind = it.k;
          t.out_byte   = it.d;
          t.last       = 1'b1;
          expected_tokens.push_back(t);
        end
      end
      if (cfg.valid && cfg.ready) colour_byte = cfg.color_escape_byte;
      // token taken: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token with none expected, kind", int'(out_ch.token_kind), -1);
        end else begin
          want = expected_tokens.pop_front();
          if (out_ch.token_kind !== want.token_kind)
            report_mismatch("token_kind", int'(out_ch.token_kind), int'(want.token_kind));
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_ch.out_byte), int'(want.out_byte));
          if (out_ch.last !== want.last)
            report_mismatch("last", int'(out_ch.last), int'(want.last));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one byte; valid stays high into the next offer unless a gap is drawn
  task automatic offer_byte(input text_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_bytes.push_back(it);
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= it.b;
    in_ch.end_of_input <= it.e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] b, input logic e);
    text_item_t it;
    it.b       = b;
    it.e       = e;
    it.n_typed = PREDICTED;
    it.k       = csvt_pkg::TK_DATA;
    it.d       = 8'h00;
    offer_byte(it);
  endtask

  // wait until every expected token is back, then let the block go quiet
  task automatic drain_tokens();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0 || offered_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_colour(input logic [7:0] v);
    cfg.valid             <= 1'b1;
    cfg.color_escape_byte <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // cell content: letters most often, with escapes, quotes, separators and noise
  function automatic logic [7:0] text_byte();
    int r;
    logic [7:0] esc_letters [0:3];
    esc_letters = '{csvt_pkg::CH_N, csvt_pkg::CH_C, csvt_pkg::CH_R, csvt_pkg::CH_T};
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 46) return csvt_pkg::CH_BSLASH;
    if (r < 57) return esc_letters[2'($urandom_range(0, 3))];
    if (r < 62) return csvt_pkg::CH_COMMA;
    if (r < 67) return csvt_pkg::CH_LF;
    if (r < 71) return csvt_pkg::CH_QUOTE;
    if (r < 74) return csvt_pkg::CH_CR;
    if (r < 77) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // one cell, quoted or plain, and most often a separator after it
  task automatic send_record_cell();
    int         shape;
    int         len;
    logic [7:0] c;
    shape = $urandom_range(0, 3);
    len   = $urandom_range(0, 6);
    if (shape == 0) begin
      send_text(csvt_pkg::CH_QUOTE, 1'b0);
      for (int i = 0; i < len; i++) begin
        c = text_byte();
        send_text(c, 1'b0);
        // inside quotes a quote is written twice
        if (c == csvt_pkg::CH_QUOTE) send_text(csvt_pkg::CH_QUOTE, 1'b0);
      end
      send_text(csvt_pkg::CH_QUOTE, $urandom_range(0, 19) == 0);
    end else begin
      for (int i = 0; i < len; i++) send_text(text_byte(), $urandom_range(0, 99) == 0);
    end
    shape = $urandom_range(0, 99);
    if (shape < 55) begin
      send_text(csvt_pkg::CH_COMMA, 1'b0);
    end else if (shape < 80) begin
      send_text(csvt_pkg::CH_LF, 1'b0);
    end else if (shape < 88) begin
      send_text(csvt_pkg::CH_CR, 1'b0);
      send_text(csvt_pkg::CH_LF, 1'b0);
    end else if (shape < 95) begin
      // end of text on some byte, flushes the open row
      send_text(text_byte(), 1'b1);
    end
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
    int  first;
    bit  held;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first = items_sent;
    held  = 1'b0;
    while (items_sent - first < PHASE_LEN) begin
      // sender keeps offering while the receiver sits out its hold-off
      if (with_hold && !held && items_sent - first >= 100) begin
        hold_req <= 1'b1;
        held = 1'b1;
      end
      send_record_cell();
    end
  endtask

  initial begin
    text_item_t it;
    mismatch_count = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    tx_idle_pct    = 16;
    rx_idle_pct    = 60;
    hold_req       = 1'b0;
    rst                   <= 1'b1;
    in_ch.valid           <= 1'b0;
    in_ch.in_byte         <= 8'h00;
    in_ch.end_of_input    <= 1'b0;
    cfg.valid             <= 1'b0;
    cfg.color_escape_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at the reset colour byte
    for (int i = 0; i < N_DIR; i++) begin
      it = dir_rows[i];
      offer_byte(it);
    end
    drain_tokens();

    write_colour(8'h00);   // colour escape now cuts the cell
    run_random_phase(16, 60, 1'b0);
    drain_tokens();

    write_colour(8'hFF);
    run_random_phase(60, 16, 1'b0);
    drain_tokens();

    write_colour(8'($urandom_range(1, 254)));
    run_random_phase(0, 0, 1'b1);
    drain_tokens();

    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
